@@ sv/efws_pkg.sv @@
// shared types, constants and helper functions for the earliest-free worker scheduler
package efws_pkg;

    localparam int MAX_WORKERS = 64;
    localparam int TIME_BITS   = 48;
    localparam int DUR_BITS    = 32;
    localparam int WID_BITS    = 6;
    localparam int CFG_BITS    = 7;
    localparam int ADDR_BITS   = $clog2(MAX_WORKERS);
    localparam int CNT_BITS    = ADDR_BITS + 1;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [DUR_BITS-1:0]  dur_t;
    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [CFG_BITS-1:0]  cfg_t;

    // one heap slot: finish time and the worker that owns it
    typedef struct packed {
        time_t finish;
        addr_t worker;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_EMIT,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_SEL,
        ST_DN_CMP
    } state_t;

    // heap order: earlier finish first, lower worker index on a tie
    function automatic logic earlier(entry_t a, entry_t b);
        return (a.finish < b.finish) || ((a.finish == b.finish) && (a.worker < b.worker));
    endfunction

    // finish time, saturating at the top of the time range
    function automatic time_t sat_add(time_t a, dur_t d);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(d);
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

endpackage

@@ sv/earliest_free_worker_scheduler.sv @@
// top level: assigns each job to the earliest-free worker through a min-heap in ram
//
// Usage
//   in channel (in_valid/in_ready/duration): one job duration per word.
//   out channel (out_valid/out_ready/worker_id/start_time): one word per job,
//   in job order. cfg_we/cfg_data write worker_count while the block is idle.
//   While fewer than worker_count workers are in use a job takes the next
//   unused worker at time 0; afterwards it takes the heap top and starts at
//   its finish time.
// Flow
//   A new worker's result word goes from accept through EMIT into the output
//   register; a heap top job reads the top in TOP before EMIT. in_ready stays
//   low from accept through the heap repair: sift-up steps through UP_RD and
//   UP_CMP per level, sift-down through DN_RD, DN_SEL and DN_CMP per level
//   (read both children, pick one, compare with the moving entry), all
//   through the single shared comparator. One job is in work at a time.
// Reset and stalls
//   Reset empties the heap and sets worker_count to 1; heap ram is not cleared.
//   A stalled receiver holds the result word; the next job's result waits
//   in the block until the output register frees up.
module earliest_free_worker_scheduler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [efws_pkg::DUR_BITS-1:0]        duration,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [efws_pkg::WID_BITS-1:0]        worker_id,
    output logic [efws_pkg::TIME_BITS-1:0]       start_time,
    input  logic                                 cfg_we,
    input  logic [efws_pkg::CFG_BITS-1:0]        cfg_data
);

    efws_pkg::state_t state_reg, state_next;
    efws_pkg::cfg_t   cfg_reg;
    efws_pkg::cnt_t   size_reg;
    efws_pkg::addr_t  pos_reg;
    efws_pkg::entry_t elem_reg;
    efws_pkg::entry_t best_reg;
    efws_pkg::addr_t  best_idx_reg;
    efws_pkg::dur_t   dur_reg;
    logic             is_pop_reg;
    efws_pkg::addr_t  res_worker_reg;
    efws_pkg::time_t  res_start_reg;
    logic             out_valid_reg;
    logic [efws_pkg::WID_BITS-1:0] out_worker_reg;
    efws_pkg::time_t  out_start_reg;

    logic             ram_we;
    efws_pkg::addr_t  ram_waddr;
    efws_pkg::entry_t ram_wdata;
    efws_pkg::addr_t  ram_raddr0;
    efws_pkg::addr_t  ram_raddr1;
    logic [efws_pkg::ENTRY_BITS-1:0] ram_rdata0_raw;
    logic [efws_pkg::ENTRY_BITS-1:0] ram_rdata1_raw;
    efws_pkg::entry_t ram_rdata0;
    efws_pkg::entry_t ram_rdata1;

    efws_pkg::cnt_t   limit;
    logic             do_insert;
    logic             accept;
    logic             out_free;
    logic             out_load;
    efws_pkg::addr_t  parent;
    efws_pkg::cnt_t   left;
    efws_pkg::cnt_t   right;
    logic             l_ok;
    logic             r_ok;
    efws_pkg::entry_t cmp_a;
    efws_pkg::entry_t cmp_b;
    logic             cmp_lt;

    // heap storage
    efws_ram #(
        .WIDTH (efws_pkg::ENTRY_BITS),
        .DEPTH (efws_pkg::MAX_WORKERS)
    ) u_heap_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .rdata0 (ram_rdata0_raw),
        .raddr1 (ram_raddr1),
        .rdata1 (ram_rdata1_raw)
    );

    assign ram_rdata0 = efws_pkg::entry_t'(ram_rdata0_raw);
    assign ram_rdata1 = efws_pkg::entry_t'(ram_rdata1_raw);

    // worker limit: zero counts as one, clamp at capacity
    always_comb
    begin
        if (cfg_reg == '0)
            limit = efws_pkg::cnt_t'(1);
        else if (efws_pkg::CNT_BITS'(cfg_reg) > efws_pkg::cnt_t'(efws_pkg::MAX_WORKERS))
            limit = efws_pkg::cnt_t'(efws_pkg::MAX_WORKERS);
        else
            limit = efws_pkg::cnt_t'(cfg_reg);
    end

    assign do_insert = size_reg < limit;
    assign in_ready  = (state_reg == efws_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == efws_pkg::ST_EMIT) && out_free;

    // heap index arithmetic
    assign parent = efws_pkg::addr_t'((pos_reg - 1'b1) >> 1);
    assign left   = {pos_reg, 1'b1};
    assign right  = left + 1'b1;
    assign l_ok   = left < size_reg;
    assign r_ok   = right < size_reg;

    // shared comparator operand select
    always_comb
    begin
        cmp_a = elem_reg;
        cmp_b = ram_rdata0;
        unique case (state_reg)
            efws_pkg::ST_DN_SEL:
            begin
                cmp_a = ram_rdata1;
                cmp_b = ram_rdata0;
            end
            efws_pkg::ST_DN_CMP:
            begin
                cmp_a = best_reg;
                cmp_b = elem_reg;
            end
            default:
            begin
                cmp_a = elem_reg;
                cmp_b = ram_rdata0;
            end
        endcase
    end

    assign cmp_lt = efws_pkg::earlier(cmp_a, cmp_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            efws_pkg::ST_IDLE:
                if (accept)
                    state_next = do_insert ? efws_pkg::ST_EMIT : efws_pkg::ST_TOP;
            efws_pkg::ST_TOP:
                state_next = efws_pkg::ST_EMIT;
            efws_pkg::ST_EMIT:
                if (out_free)
                    state_next = is_pop_reg ? efws_pkg::ST_DN_RD : efws_pkg::ST_UP_RD;
            efws_pkg::ST_UP_RD:
                state_next = (pos_reg == '0) ? efws_pkg::ST_IDLE : efws_pkg::ST_UP_CMP;
            efws_pkg::ST_UP_CMP:
                state_next = cmp_lt ? efws_pkg::ST_UP_RD : efws_pkg::ST_IDLE;
            efws_pkg::ST_DN_RD:
                state_next = l_ok ? efws_pkg::ST_DN_SEL : efws_pkg::ST_IDLE;
            efws_pkg::ST_DN_SEL:
                state_next = efws_pkg::ST_DN_CMP;
            efws_pkg::ST_DN_CMP:
                state_next = cmp_lt ? efws_pkg::ST_DN_RD : efws_pkg::ST_IDLE;
            default:
                state_next = efws_pkg::ST_IDLE;
        endcase
    end

    // ram port control
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = elem_reg;
        ram_raddr0 = '0;
        ram_raddr1 = '0;
        unique case (state_reg)
            efws_pkg::ST_UP_RD:
            begin
                ram_raddr0 = parent;
                ram_we     = (pos_reg == '0);
            end
            efws_pkg::ST_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = cmp_lt ? ram_rdata0 : elem_reg;
            end
            efws_pkg::ST_DN_RD:
            begin
                ram_raddr0 = left[efws_pkg::ADDR_BITS-1:0];
                ram_raddr1 = right[efws_pkg::ADDR_BITS-1:0];
                ram_we     = !l_ok;
            end
            efws_pkg::ST_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = cmp_lt ? best_reg : elem_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efws_pkg::ST_IDLE;
            cfg_reg       <= efws_pkg::cfg_t'(1);
            size_reg      <= '0;
            is_pop_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cfg_reg <= cfg_data;
            if (accept)
            begin
                is_pop_reg <= !do_insert;
                if (do_insert)
                    size_reg <= size_reg + 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dur_reg <= duration;
            if (do_insert)
            begin
                pos_reg         <= size_reg[efws_pkg::ADDR_BITS-1:0];
                elem_reg.finish <= efws_pkg::TIME_BITS'(duration);
                elem_reg.worker <= size_reg[efws_pkg::ADDR_BITS-1:0];
                res_worker_reg  <= size_reg[efws_pkg::ADDR_BITS-1:0];
                res_start_reg   <= '0;
            end
            else
            begin
                pos_reg <= '0;
            end
        end
        unique case (state_reg)
            efws_pkg::ST_TOP:
            begin
                elem_reg.finish <= efws_pkg::sat_add(ram_rdata0.finish, dur_reg);
                elem_reg.worker <= ram_rdata0.worker;
                res_worker_reg  <= ram_rdata0.worker;
                res_start_reg   <= ram_rdata0.finish;
            end
            efws_pkg::ST_UP_CMP:
                if (cmp_lt)
                    pos_reg <= parent;
            efws_pkg::ST_DN_SEL:
                if (r_ok && cmp_lt)
                begin
                    best_reg     <= ram_rdata1;
                    best_idx_reg <= right[efws_pkg::ADDR_BITS-1:0];
                end
                else
                begin
                    best_reg     <= ram_rdata0;
                    best_idx_reg <= left[efws_pkg::ADDR_BITS-1:0];
                end
            efws_pkg::ST_DN_CMP:
                if (cmp_lt)
                    pos_reg <= best_idx_reg;
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_worker_reg <= efws_pkg::WID_BITS'(res_worker_reg);
            out_start_reg  <= res_start_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign worker_id  = out_worker_reg;
    assign start_time = out_start_reg;

endmodule

@@ sv/efws_ram.sv @@
// generic ram: one write port, two registered read ports
module efws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [WIDTH-1:0]         rdata0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ sv/efws_checker.sv @@
// port-level checks for the scheduler, bound to the top level
module efws_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [efws_pkg::DUR_BITS-1:0]  duration,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [efws_pkg::WID_BITS-1:0]  worker_id,
    input logic [efws_pkg::TIME_BITS-1:0] start_time,
    input logic                           cfg_we,
    input logic [efws_pkg::CFG_BITS-1:0]  cfg_data
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(worker_id) && $stable(start_time))
        else $error("result word changed while stalled");

    // one job at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous job still in work");

    // a new result only comes out of a job in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result appeared with no job in work");

    // config is only written while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> in_ready)
        else $error("worker count written while busy");

endmodule

bind earliest_free_worker_scheduler efws_checker u_efws_checker (.*);

@@ sim/efws_assignment_checker.sv @@
// checker for the earliest-free worker scheduler: predicts each job assignment and compares results
module efws_assignment_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [efws_pkg::DUR_BITS-1:0]  duration,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [efws_pkg::WID_BITS-1:0]  worker_id,
    input  logic [efws_pkg::TIME_BITS-1:0] start_time,
    input  logic                           cfg_we,
    input  logic [efws_pkg::CFG_BITS-1:0]  cfg_data,
    output int unsigned                    outstanding,
    output int unsigned                    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam efws_pkg::time_t TIME_TOP = {efws_pkg::TIME_BITS{1'b1}};

    // one predicted result word
    typedef struct packed {
        logic [efws_pkg::WID_BITS-1:0] worker;
        efws_pkg::time_t               start;
    } assignment_t;

    // private copy of the heap and counters
    efws_pkg::time_t busy_until [efws_pkg::MAX_WORKERS];
    logic [6:0]      owner      [efws_pkg::MAX_WORKERS];
    int unsigned     used_slots;
    logic [6:0]      next_fresh;
    efws_pkg::cfg_t  crew_size;
    assignment_t     due_q [$];

    // heap order: earlier finish first, lower worker on a tie
    function automatic logic goes_first(int unsigned a, int unsigned b);
        if (busy_until[a] != busy_until[b])
            return busy_until[a] < busy_until[b];
        return owner[a] < owner[b];
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        efws_pkg::time_t t;
        logic [6:0]      w;
        t             = busy_until[a];
        w             = owner[a];
        busy_until[a] = busy_until[b];
        owner[a]      = owner[b];
        busy_until[b] = t;
        owner[b]      = w;
    endfunction

    // hand one job to a worker and update the heap copy
    function automatic assignment_t place_job(efws_pkg::dur_t d);
        int unsigned cap;
        int unsigned pos;
        int unsigned pick;
        int unsigned kid;
        assignment_t r;
        if (crew_size == 0)
            cap = 1;
        else if (crew_size > efws_pkg::MAX_WORKERS)
            cap = efws_pkg::MAX_WORKERS;
        else
            cap = crew_size;

        if (used_slots < cap) begin
            // an unused worker starts at time zero
            r.worker        = next_fresh[efws_pkg::WID_BITS-1:0];
            r.start         = '0;
            pos             = used_slots;
            busy_until[pos] = efws_pkg::time_t'(d);
            owner[pos]      = next_fresh;
            used_slots++;
            next_fresh      = next_fresh + 7'd1;
            while (pos > 0 && goes_first(pos, (pos - 1) / 2)) begin
                swap_slots(pos, (pos - 1) / 2);
                pos = (pos - 1) / 2;
            end
        end
        else begin
            // earliest-free worker takes the job, finish time pins at the top
            r.worker      = owner[0][efws_pkg::WID_BITS-1:0];
            r.start       = busy_until[0];
            if (r.start > TIME_TOP - efws_pkg::time_t'(d))
                busy_until[0] = TIME_TOP;
            else
                busy_until[0] = r.start + efws_pkg::time_t'(d);
            pick = 0;
            do begin
                pos = pick;
                kid = 2 * pos + 1;
                if (kid < used_slots && goes_first(kid, pick))
                    pick = kid;
                if (kid + 1 < used_slots && goes_first(kid + 1, pick))
                    pick = kid + 1;
                if (pick != pos)
                    swap_slots(pos, pick);
            end while (pick != pos);
        end
        return r;
    endfunction

    // predict on accepted jobs, follow register writes, check accepted results
    always @(posedge clk or negedge rst_n) begin : watch
        assignment_t want;
        int unsigned bad;
        if (!rst_n) begin
            crew_size  = 7'd1;
            used_slots = 0;
            next_fresh = '0;
            due_q.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else begin
            bad = 0;
            if (in_valid && in_ready)
                due_q = {due_q, place_job(duration)};
            if (cfg_we)
                crew_size = cfg_data;
            if (out_valid && out_ready) begin
                if (due_q.size() == 0) begin
                    $display("%0d ns: unexpected word, expected none, actual worker %0d start %0d",
                             $time, worker_id, start_time);
                    bad++;
                end
                else begin
                    want = due_q.pop_front();
                    if (worker_id !== want.worker) begin
                        $display("%0d ns: worker_id expected %0d actual %0d",
                                 $time, want.worker, worker_id);
                        bad++;
                    end
                    if (start_time !== want.start) begin
                        $display("%0d ns: start_time expected %0d actual %0d",
                                 $time, want.start, start_time);
                        bad++;
                    end
                end
            end
            outstanding <= due_q.size();
            mismatches  <= mismatches + bad;
        end
    end

endmodule

@@ sim/testbench.sv @@
// testbench top: drives job words and worker count writes into the scheduler and gives the verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PHASES  = 8;
    localparam int JOBS_PER_PHASE = 135;
    localparam int TOP_RUN_JOBS   = 20;
    localparam int SETTLE_CYCLES  = 40;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    efws_pkg::dur_t                duration;
    logic                          out_valid;
    logic                          out_ready;
    logic [efws_pkg::WID_BITS-1:0] worker_id;
    efws_pkg::time_t               start_time;
    logic                          cfg_we;
    efws_pkg::cfg_t                cfg_data;
    int unsigned                   outstanding;
    int unsigned                   mismatches;
    int unsigned                   stall_left;
    bit                            no_idle = 1'b0;

    earliest_free_worker_scheduler uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .duration   (duration),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .worker_id  (worker_id),
        .start_time (start_time),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    efws_assignment_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .duration    (duration),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .worker_id   (worker_id),
        .start_time  (start_time),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result side: hold ready low for a random count after each word, none while no_idle is set
    always @(posedge clk or negedge rst_n) begin : result_side
        int unsigned n;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else begin
            if (out_valid && out_ready)
                n = no_idle ? 0 : $urandom_range(0, 7);
            else
                n = (stall_left > 0) ? stall_left - 1 : 0;
            stall_left <= n;
            out_ready  <= (n == 0);
        end
    end

    // mix of tiny, medium, full-range, power-of-two and top durations
    function automatic efws_pkg::dur_t pick_duration();
        case ($urandom_range(0, 5))
            0:       return efws_pkg::dur_t'($urandom_range(0, 3));
            1:       return efws_pkg::dur_t'($urandom_range(0, 255));
            2:       return efws_pkg::dur_t'($urandom);
            3:       return {efws_pkg::DUR_BITS{1'b1}};
            4:       return efws_pkg::dur_t'(1) << $urandom_range(0, efws_pkg::DUR_BITS - 1);
            default: return efws_pkg::dur_t'($urandom_range(0, 100000));
        endcase
    endfunction

    // wait at a falling edge until every expected word has arrived
    task automatic wait_drained();
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // offer one job word, after a random gap or a full drain
    task automatic send_job(input efws_pkg::dur_t d, input bit drain);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0 || drain) begin
            in_valid <= 1'b0;
            if (drain)
                wait_drained();
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        duration <= d;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // stop sending and let the heap repair finish
    task automatic settle();
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_crew(input efws_pkg::cfg_t v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        efws_pkg::cfg_t plan [RANDOM_PHASES];
        rst_n    = 1'b0;
        in_valid = 1'b0;
        duration = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        plan     = '{7'd9, 7'd16, 7'd0, 7'd30, 7'd2, 7'd50, 7'd64, 7'd127};
        plan[3]  = efws_pkg::cfg_t'($urandom_range(17, 40));
        plan[5]  = efws_pkg::cfg_t'($urandom_range(41, 63));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset worker count of one: zero and top durations on the single worker
        send_job(32'd0, 1'b0);
        send_job(32'hFFFF_FFFF, 1'b0);
        send_job(32'd1, 1'b0);
        send_job(32'h8000_0000, 1'b0);
        send_job(32'h7FFF_FFFF, 1'b0);

        // back-to-back top durations piling up on the single worker
        no_idle <= 1'b1;
        repeat (TOP_RUN_JOBS) send_job(32'hFFFF_FFFF, 1'b0);
        no_idle <= 1'b0;
        send_job(32'd0, 1'b0);
        send_job(32'h5555_AAAA, 1'b0);

        // worker count zero acts as one
        settle();
        set_crew(7'd0);
        send_job(32'd3, 1'b0);
        send_job(32'hAAAA_5555, 1'b0);

        // raised after the heap filled: new workers at time zero, ties to the lower index
        settle();
        set_crew(7'd3);
        send_job(32'd4, 1'b0);
        send_job(32'd4, 1'b0);
        send_job(32'd0, 1'b0);
        send_job(32'd0, 1'b0);
        send_job(32'd2, 1'b0);
        send_job(32'd0, 1'b0);

        // above the worker limit acts as the limit
        settle();
        set_crew(7'd127);
        send_job(32'd10, 1'b0);
        send_job(32'd10, 1'b0);

        // lowered below the heap size: all workers in use stay in rotation
        settle();
        set_crew(7'd2);
        send_job(32'd1, 1'b0);
        send_job(32'd0, 1'b0);
        send_job(32'd3, 1'b0);

        // random phases over a spread of worker counts
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            no_idle <= (p == 4) || ($urandom_range(0, 3) == 0);
            set_crew(plan[p]);
            repeat (JOBS_PER_PHASE)
                send_job(pick_duration(), $urandom_range(0, 39) == 0);
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hard stop if the handshakes hang
    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
